// File: src/dmcs_pkg.sv
// dmcs_pkg: shared types and constants of the mailbox command sequencer
// used by every module under src; depends on nothing
`timescale 1ns / 1ps

package dmcs_pkg;

  // reply kinds as seen on the result channel
  localparam logic [1:0] KIND_SYNC      = 2'd0;
  localparam logic [1:0] KIND_WORD      = 2'd1;
  localparam logic [1:0] KIND_FRAME_END = 2'd2;

  // reply group codes passed from front to back
  localparam logic [1:0] OP_ACK_NORMAL = 2'd0;  // sync notice then acknowledge word
  localparam logic [1:0] OP_ACK_LIGHT  = 2'd1;  // single light acknowledge word
  localparam logic [1:0] OP_BUFFER     = 2'd2;  // sync notice, buffer word, maybe frame end

  // command bytes
  localparam logic [6:0] CMD_VOICES = 7'h01;
  localparam logic [6:0] CMD_FRAME  = 7'h02;

  // fixed list lengths of the light protocol
  localparam logic [15:0] LIGHT_LEN_VOICES = 16'd5;
  localparam logic [15:0] LIGHT_LEN_FRAME  = 16'd3;

  // upper parts of the literal reply words
  localparam logic [15:0] ACK_NORMAL_HI = 16'hF355;
  localparam logic [15:0] ACK_LIGHT_HI  = 16'h8000;
  localparam logic [23:0] BUFFER_HI     = 24'hF355FF;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // one queued reply group
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] tag;        // acknowledge tag, or buffer index in the low byte
    logic        frame_end;  // buffer group closes the frame
  } reply_desc_t;

  // push side of the queue
  typedef struct packed {
    logic        valid;
    reply_desc_t desc;
  } reply_push_t;

endpackage

// File: src/dmcs_front.sv
// dmcs_front: accepts mailbox words, keeps the protocol state, classifies replies
// depends on dmcs_pkg; feeds dmcs_queue
`timescale 1ns / 1ps

module dmcs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [31:0]          mail,
  input  logic                 cfg_we,
  input  logic                 cfg_light,
  output dmcs_pkg::reply_push_t push
);

  logic        light_r,         light_nxt;
  logic        sync_wait_r,     sync_wait_nxt;
  logic        frame_pending_r, frame_pending_nxt;
  logic        list_active_r,   list_active_nxt;
  logic [15:0] received_r,      received_nxt;
  logic [15:0] expected_r,      expected_nxt;
  logic [31:0] first_r,         first_nxt;
  logic [15:0] voice_total_r,   voice_total_nxt;
  logic [7:0]  buf_index_r,     buf_index_nxt;
  logic [7:0]  buf_total_r,     buf_total_nxt;

  logic        take;
  logic [15:0] rec_eff;
  logic [15:0] exp_eff;
  logic [15:0] rec_inc;
  logic [31:0] first_eff;
  logic [6:0]  cmd;
  logic [4:0]  voice_hi;
  logic [8:0]  voice_next;
  logic [7:0]  buf_inc;

  assign voice_hi   = {1'b0, mail[19:16]} + 5'd1;
  assign voice_next = {voice_hi, 4'b0000};
  assign buf_inc    = buf_index_r + 8'd1;

  // protocol state update for one accepted beat
  always_comb begin
    light_nxt         = cfg_we ? cfg_light : light_r;
    sync_wait_nxt     = sync_wait_r;
    frame_pending_nxt = frame_pending_r;
    list_active_nxt   = list_active_r;
    received_nxt      = received_r;
    expected_nxt      = expected_r;
    first_nxt         = first_r;
    voice_total_nxt   = voice_total_r;
    buf_index_nxt     = buf_index_r;
    buf_total_nxt     = buf_total_r;
    push              = '0;
    take              = 1'b0;
    rec_eff           = received_r;
    exp_eff           = expected_r;
    rec_inc           = '0;
    first_eff         = first_r;
    cmd               = mail[30:24];

    if (accept) begin
      if (light_r) begin
        // light protocol: command byte fixes the list length
        if (!list_active_r) begin
          rec_eff = '0;
          priority if (cmd == dmcs_pkg::CMD_VOICES) begin
            exp_eff = dmcs_pkg::LIGHT_LEN_VOICES;
            take    = 1'b1;
          end else if (cmd == dmcs_pkg::CMD_FRAME) begin
            exp_eff = dmcs_pkg::LIGHT_LEN_FRAME;
            take    = 1'b1;
          end else begin
            exp_eff = '0;
          end
          expected_nxt = exp_eff;
          if (take) begin
            list_active_nxt = 1'b1;
            received_nxt    = '0;
          end
        end else begin
          take = 1'b1;
        end
      end else begin
        priority if (sync_wait_r) begin
          // sync data word checks its voice field against the voice total and may advance the buffer counter
          sync_wait_nxt = 1'b0;
          if (frame_pending_r && ({7'b0, voice_next} >= voice_total_r)) begin
            buf_index_nxt       = buf_inc;
            push.valid          = 1'b1;
            push.desc.op        = dmcs_pkg::OP_BUFFER;
            push.desc.tag       = {8'b0, buf_inc};
            push.desc.frame_end = (buf_inc == buf_total_r);
            if (buf_inc == buf_total_r) begin
              frame_pending_nxt = 1'b0;
            end
          end
        end else if (list_active_r) begin
          take = 1'b1;
        end else if (mail == 32'd0) begin
          sync_wait_nxt = 1'b1;
        end else if (mail[31:16] == 16'd0) begin
          list_active_nxt = 1'b1;
          expected_nxt    = mail[15:0];
          received_nxt    = '0;
        end else begin
          // debug or unknown word: ignored
        end
      end

      // list word; only the first word of a list is ever used, later ones just count
      if (take) begin
        rec_inc      = rec_eff + 16'd1;
        received_nxt = rec_inc;
        if (rec_eff == 16'd0) begin
          first_eff = mail;
          first_nxt = mail;
        end
        if (rec_inc >= exp_eff) begin
          list_active_nxt = 1'b0;
          if (first_eff[30:24] == dmcs_pkg::CMD_VOICES) begin
            voice_total_nxt = first_eff[15:0];
          end
          if (first_eff[30:24] == dmcs_pkg::CMD_FRAME) begin
            buf_index_nxt = '0;
            buf_total_nxt = first_eff[23:16];
          end
          if (!light_r && first_eff[30:24] == dmcs_pkg::CMD_FRAME) begin
            frame_pending_nxt = 1'b1;
          end else begin
            push.valid          = 1'b1;
            push.desc.op        = light_r ? dmcs_pkg::OP_ACK_LIGHT : dmcs_pkg::OP_ACK_NORMAL;
            push.desc.tag       = first_eff[31:16];
            push.desc.frame_end = 1'b0;
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r         <= 1'b0;
      sync_wait_r     <= 1'b0;
      frame_pending_r <= 1'b0;
      list_active_r   <= 1'b0;
      received_r      <= '0;
      expected_r      <= '0;
      first_r         <= '0;
      voice_total_r   <= '0;
      buf_index_r     <= '0;
      buf_total_r     <= '0;
    end else begin
      light_r         <= light_nxt;
      sync_wait_r     <= sync_wait_nxt;
      frame_pending_r <= frame_pending_nxt;
      list_active_r   <= list_active_nxt;
      received_r      <= received_nxt;
      expected_r      <= expected_nxt;
      first_r         <= first_nxt;
      voice_total_r   <= voice_total_nxt;
      buf_index_r     <= buf_index_nxt;
      buf_total_r     <= buf_total_nxt;
    end
  end

endmodule

// File: src/dmcs_queue.sv
// dmcs_queue: short queue of reply groups between front and back
// depends on dmcs_pkg
`timescale 1ns / 1ps

module dmcs_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dmcs_pkg::reply_push_t push,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output dmcs_pkg::reply_desc_t head
);

  dmcs_pkg::reply_desc_t entry_r [dmcs_pkg::Q_DEPTH];
  logic [dmcs_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [dmcs_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [dmcs_pkg::Q_AW:0]   count_r,  count_nxt;
  logic                      do_push;
  logic                      do_pop;

  assign full      = (count_r == (dmcs_pkg::Q_AW+1)'(dmcs_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (dmcs_pkg::Q_AW+1)'(do_push) - (dmcs_pkg::Q_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.desc;
    end
  end

endmodule

// File: src/dmcs_back.sv
// dmcs_back: expands queued reply groups into reply beats, one per cycle while out_stall is low
// depends on dmcs_pkg; drains dmcs_queue
`timescale 1ns / 1ps

module dmcs_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  dmcs_pkg::reply_desc_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_reply_kind,
  output logic [31:0]           out_reply_word,
  output logic                  out_raise_interrupt,
  output logic                  out_last
);

  logic [1:0]  step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic [1:0]  kind_r;
  logic [31:0] word_r;
  logic        irq_r;
  logic        last_r;

  logic        load;
  logic [1:0]  kind_c;
  logic [31:0] word_c;
  logic        irq_c;
  logic        last_c;

  assign load = q_not_empty && (!valid_r || !out_stall);

  // reply for the current step of the head group
  always_comb begin
    kind_c = dmcs_pkg::KIND_SYNC;
    word_c = '0;
    irq_c  = 1'b0;
    last_c = 1'b0;
    unique case (q_head.op)
      dmcs_pkg::OP_ACK_LIGHT: begin
        kind_c = dmcs_pkg::KIND_WORD;
        word_c = {dmcs_pkg::ACK_LIGHT_HI, q_head.tag};
        last_c = 1'b1;
      end
      dmcs_pkg::OP_ACK_NORMAL: begin
        if (step_r == 2'd0) begin
          irq_c = 1'b1;
        end else begin
          kind_c = dmcs_pkg::KIND_WORD;
          word_c = {dmcs_pkg::ACK_NORMAL_HI, q_head.tag};
          last_c = 1'b1;
        end
      end
      dmcs_pkg::OP_BUFFER: begin
        priority if (step_r == 2'd0) begin
          irq_c = 1'b1;
        end else if (step_r == 2'd1) begin
          kind_c = dmcs_pkg::KIND_WORD;
          word_c = {dmcs_pkg::BUFFER_HI, q_head.tag[7:0]};
          last_c = !q_head.frame_end;
        end else begin
          kind_c = dmcs_pkg::KIND_FRAME_END;
          last_c = 1'b1;
        end
      end
      default: begin
        last_c = 1'b1;
      end
    endcase
  end

  // step through the group, pop on its final beat
  always_comb begin
    q_pop     = load && last_c;
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (load) begin
      step_nxt  = last_c ? 2'd0 : step_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_c;
      word_r <= word_c;
      irq_r  <= irq_c;
      last_r <= last_c;
    end
  end

  assign out_valid           = valid_r;
  assign out_reply_kind      = kind_r;
  assign out_reply_word      = word_r;
  assign out_raise_interrupt = irq_r;
  assign out_last            = last_r;

endmodule

// File: src/dsp_mailbox_command_sequencer.sv
// dsp_mailbox_command_sequencer: top level of the mailbox command sequencer
// depends on dmcs_pkg, dmcs_front, dmcs_queue, dmcs_back
`timescale 1ns / 1ps

// Takes one 32-bit mailbox word per beat and sends zero to three reply beats
// for it, the final one flagged by out_last. A word is taken whenever the
// four-entry reply queue has room, so words that cause no reply stream in at
// one per cycle; replies leave the output register at one per cycle while
// out_stall is low, a pace set by the back end that expands each queued reply
// group beat by beat. The user must write light_mode through the cfg_ port
// (always ready) only while idle; the block itself does not enforce this.
// There is no clearing pass after reset.

module dsp_mailbox_command_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_mail,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_reply_kind,
  output logic [31:0] out_reply_word,
  output logic        out_raise_interrupt,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  dmcs_pkg::reply_push_t push;
  dmcs_pkg::reply_desc_t q_head;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;
  logic                  in_accept;

  // input beat handshake
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  dmcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .mail      (in_mail),
    .cfg_we    (cfg_valid),
    .cfg_light (cfg_data),
    .push      (push)
  );

  dmcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  dmcs_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_not_empty         (q_not_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_reply_kind      (out_reply_kind),
    .out_reply_word      (out_reply_word),
    .out_raise_interrupt (out_raise_interrupt),
    .out_last            (out_last)
  );

endmodule

// File: sim/dmcs_checker.sv
// dmcs_checker: watches the mailbox, reply and cfg channels of the sequencer,
// predicts every reply beat and compares it with what the block sends
// depends on dmcs_pkg
`timescale 1ns / 1ps

module dmcs_checker
  import dmcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_mail,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_reply_kind,
  input  logic [31:0] out_reply_word,
  input  logic        out_raise_interrupt,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          fail_count,
  output int          replies_owed
);

  localparam int LIST_WORDS = 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic        irq;
    logic        last;
  } reply_t;

  // predicted sequencer state
  logic        light_mode;
  logic        sync_wait;
  logic        frame_pending;
  logic        list_active;
  logic [15:0] words_received;
  logic [15:0] words_expected;
  logic [31:0] list_store [LIST_WORDS];
  logic [15:0] voice_total;
  logic [8:0]  next_voice;
  logic [7:0]  buffer_index;
  logic [7:0]  buffer_total;

  reply_t replies_due [$];
  reply_t mail_replies [$];

  task automatic queue_reply(input logic [1:0] kind, input logic [31:0] word,
                             input logic irq);
    reply_t r;
    r.kind = kind;
    r.word = word;
    r.irq  = irq;
    r.last = 1'b0;
    mail_replies.push_back(r);
  endtask

  // completed list: store counts and queue the acknowledge replies, none for a frame command in normal mode
  task automatic run_command();
    logic [31:0] first;
    logic [6:0]  cmd;
    logic [15:0] tag;
    logic        silent;
    first  = list_store[0];
    cmd    = first[30:24];
    tag    = first[31:16];
    silent = 1'b0;
    if (cmd == CMD_VOICES) begin
      voice_total = first[15:0];
    end else if (cmd == CMD_FRAME) begin
      buffer_index = '0;
      buffer_total = first[23:16];
      if (!light_mode) begin
        frame_pending = 1'b1;
        silent = 1'b1;
      end
    end
    if (!silent) begin
      if (light_mode) begin
        queue_reply(KIND_WORD, {ACK_LIGHT_HI, tag}, 1'b0);
      end else begin
        queue_reply(KIND_SYNC, '0, 1'b1);
        queue_reply(KIND_WORD, {ACK_NORMAL_HI, tag}, 1'b0);
      end
    end
  endtask

  // list words past the store are counted but dropped
  task automatic take_list_word(input logic [31:0] mail);
    if (words_received < LIST_WORDS)
      list_store[words_received[2:0]] = mail;
    words_received = words_received + 16'd1;
    if (words_received >= words_expected) begin
      list_active = 1'b0;
      run_command();
    end
  endtask

  // sync data word: advance voices and buffers while a frame is open
  task automatic take_sync_word(input logic [31:0] mail);
    logic [4:0] step;
    sync_wait = 1'b0;
    if (frame_pending) begin
      step = {1'b0, mail[19:16]} + 5'd1;
      next_voice = {step, 4'h0};
      if (next_voice >= voice_total) begin
        buffer_index = buffer_index + 8'd1;
        queue_reply(KIND_SYNC, '0, 1'b1);
        queue_reply(KIND_WORD, {BUFFER_HI, buffer_index}, 1'b0);
        next_voice = '0;
        if (buffer_index == buffer_total) begin
          queue_reply(KIND_FRAME_END, '0, 1'b0);
          frame_pending = 1'b0;
        end
      end
    end
  endtask

  // one accepted mailbox word
  task automatic advance_sequencer(input logic [31:0] mail);
    mail_replies.delete();
    if (light_mode) begin
      if (!list_active) begin
        if (mail[30:24] == CMD_VOICES)
          words_expected = LIGHT_LEN_VOICES;
        else if (mail[30:24] == CMD_FRAME)
          words_expected = LIGHT_LEN_FRAME;
        else
          words_expected = '0;
        if (words_expected != 16'd0) begin
          list_active = 1'b1;
          words_received = '0;
        end
      end
      if (list_active)
        take_list_word(mail);
    end else if (sync_wait) begin
      take_sync_word(mail);
    end else if (list_active) begin
      take_list_word(mail);
    end else if (mail == 32'd0) begin
      sync_wait = 1'b1;
    end else if (mail[31:16] == 16'd0) begin
      list_active = 1'b1;
      words_expected = mail[15:0];
      words_received = '0;
    end
    if (mail_replies.size() > 0)
      mail_replies[mail_replies.size() - 1].last = 1'b1;
    foreach (mail_replies[i])
      replies_due.push_back(mail_replies[i]);
  endtask

  // compare one reply beat with the oldest prediction
  task automatic check_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: reply beat with none predicted: kind %0d word %h irq %0b last %0b",
                 $realtime, out_reply_kind, out_reply_word, out_raise_interrupt, out_last);
    end else begin
      want = replies_due.pop_front();
      if (want.kind != out_reply_kind || want.word != out_reply_word ||
          want.irq != out_raise_interrupt || want.last != out_last) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display({"%0t: reply mismatch: expected kind %0d word %h irq %0b last %0b,",
                    " got kind %0d word %h irq %0b last %0b"},
                   $realtime, want.kind, want.word, want.irq, want.last,
                   out_reply_kind, out_reply_word, out_raise_interrupt, out_last);
      end
    end
  endtask

  initial fail_count = 0;

  // sample every channel at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      light_mode     = 1'b0;
      sync_wait      = 1'b0;
      frame_pending  = 1'b0;
      list_active    = 1'b0;
      words_received = '0;
      words_expected = '0;
      foreach (list_store[i])
        list_store[i] = '0;
      voice_total    = '0;
      next_voice     = '0;
      buffer_index   = '0;
      buffer_total   = '0;
      replies_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        light_mode = cfg_data;
      if (out_valid && !out_stall)
        check_reply();
      if (in_valid && !in_stall)
        advance_sequencer(in_mail);
    end
    replies_owed <= replies_due.size();
  end

endmodule

// File: sim/dsp_mailbox_command_sequencer_tb.sv
// dsp_mailbox_command_sequencer_tb: clock, reset, mailbox stimulus and verdict
// depends on dmcs_pkg, dmcs_checker and the dsp_mailbox_command_sequencer rtl
`timescale 1ns / 1ps

module dsp_mailbox_command_sequencer_tb;
  import dmcs_pkg::*;

  localparam logic [15:0] DEBUG_HI = 16'hCDD1;
  localparam int CHUNK_MAILS = 45;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [31:0] in_mail = '0;
  logic        out_stall = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_reply_kind;
  logic [31:0] out_reply_word;
  logic        out_raise_interrupt;
  logic        out_last;
  logic        cfg_ready;

  int   fail_count;
  int   replies_owed;
  int   send_idle_pct = 18;
  int   recv_idle_pct = 88;
  int   mails_sent = 0;
  int   chunk_end;
  logic light_now = 1'b0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  dsp_mailbox_command_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mail             (in_mail),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_reply_kind      (out_reply_kind),
    .out_reply_word      (out_reply_word),
    .out_raise_interrupt (out_raise_interrupt),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  dmcs_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mail             (in_mail),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_reply_kind      (out_reply_kind),
    .out_reply_word      (out_reply_word),
    .out_raise_interrupt (out_raise_interrupt),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .replies_owed        (replies_owed)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("dsp_mailbox_command_sequencer verification failed");
    $finish;
  end

  // reply side stall: random, or one long hold-off when asked
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // offer one mailbox word, with optional idle cycles first
  task automatic send_mail(input logic [31:0] mail);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_mail  <= mail;
    do @(posedge clk); while (in_stall);
    mails_sent++;
  endtask

  // stop offering and wait until every predicted reply is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (replies_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // protocol select, written only with the block drained
  task automatic write_mode(input logic mode);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    light_now = mode;
  endtask

  // normal protocol: a whole list, a sync pair or a stray word
  task automatic normal_burst();
    int          pick;
    int          len;
    logic [31:0] first;
    logic [6:0]  cmd;
    pick = $urandom_range(99);
    if (pick < 45) begin
      len  = $urandom_range(1, 10);
      pick = $urandom_range(99);
      if (pick < 40)
        cmd = CMD_VOICES;
      else if (pick < 75)
        cmd = CMD_FRAME;
      else
        cmd = 7'($urandom_range(127));
      first = $urandom;
      first[30:24] = cmd;
      // small voice counts and short frames so that syncs move buffers along
      if (cmd == CMD_VOICES && $urandom_range(4) != 0)
        first[15:0] = 16'($urandom_range(300));
      if (cmd == CMD_FRAME && $urandom_range(9) != 0)
        first[23:16] = 8'($urandom_range(1, 4));
      send_mail({16'h0000, 16'(len)});
      send_mail(first);
      for (int i = 1; i < len; i++)
        send_mail($urandom);
    end else if (pick < 80) begin
      send_mail('0);
      send_mail($urandom);
    end else begin
      first = ($urandom_range(2) == 0) ? {DEBUG_HI, 16'($urandom)} : $urandom;
      // keep stray words from opening a list or arming a sync
      if (first[31:16] == 16'h0000)
        first[31] = 1'b1;
      send_mail(first);
    end
  endtask

  // light protocol: fixed length lists or an unknown command byte
  task automatic light_burst();
    int          pick;
    logic [31:0] first;
    logic [6:0]  cmd;
    pick  = $urandom_range(99);
    first = $urandom;
    if (pick < 45) begin
      first[30:24] = CMD_VOICES;
      send_mail(first);
      repeat (4) send_mail($urandom);
    end else if (pick < 85) begin
      first[30:24] = CMD_FRAME;
      send_mail(first);
      repeat (2) send_mail($urandom);
    end else begin
      cmd = 7'($urandom_range(125));
      if (cmd != 7'd0)
        cmd = cmd + 7'd2;
      first[30:24] = cmd;
      send_mail(first);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);

    // ignored words: all ones and a debug word
    send_mail(32'hFFFF_FFFF);
    send_mail({DEBUG_HI, 16'h0000});
    // sync data with no frame open
    send_mail(32'h0000_0000);
    send_mail(32'h1234_5678);
    // voice count of zero
    send_mail(32'h0000_0001);
    send_mail(32'h0100_0000);
    // frame of two buffers, bit 31 of the command set
    send_mail(32'h0000_0002);
    send_mail(32'h8202_0000);
    send_mail(32'hFFFF_FFFF);
    send_mail(32'h0000_0000);
    send_mail(32'h000F_0000);
    send_mail(32'h0000_0000);
    send_mail(32'h0000_0000);
    // list longer than the store, other command code
    send_mail(32'h0000_0009);
    send_mail(32'h7F00_FFFF);
    repeat (8) send_mail($urandom);
    // list opened in normal mode and finished in light mode
    send_mail(32'h0000_0005);
    send_mail(32'h8100_0010);
    write_mode(1'b1);
    repeat (4) send_mail($urandom);
    // light frame command, then an unknown light command
    send_mail(32'h02FF_0000);
    send_mail(32'hFFFF_FFFF);
    send_mail(32'h0000_0000);
    send_mail(32'h7E00_0000);

    // random part in three idling phases, both protocols in each
    chunk_end = mails_sent;
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      if (phase == 1) begin
        send_idle_pct = 88;
        recv_idle_pct = 18;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int chunk = 0; chunk < 2; chunk++) begin
        write_mode(1'(chunk) ^ (phase == 1));
        if (phase == 2 && chunk == 0)
          hold_toggle <= ~hold_toggle;
        chunk_end = mails_sent + CHUNK_MAILS;
        while (mails_sent < chunk_end) begin
          if (light_now)
            light_burst();
          else
            normal_burst();
        end
      end
    end

    drain();
    if (fail_count == 0 && replies_owed == 0)
      $display("dsp_mailbox_command_sequencer verification clean");
    else
      $display("dsp_mailbox_command_sequencer verification failed");
    $finish;
  end

endmodule
